### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/iestat_pkg.sv
// ----------------------------------------------------------------------------
// Image extrema statistics package
// Widths, constants, report codes and record types shared by the block.
// ----------------------------------------------------------------------------
package iestat_pkg;

  localparam int CHAN_W  = 8;
  localparam int COORD_W = 12;
  localparam int SUM_W   = 10;
  localparam int WIDTH_W = 13;
  localparam int KIND_W  = 3;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 13'd4096;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [SUM_W-1:0]   DARK_START  = 10'd769;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_BRIGHT = 3'd0,
    KIND_DARK   = 3'd1,
    KIND_MAX_R  = 3'd2,
    KIND_MAX_G  = 3'd3,
    KIND_MAX_B  = 3'd4,
    KIND_MIN_R  = 3'd5,
    KIND_MIN_G  = 3'd6,
    KIND_MIN_B  = 3'd7
  } kind_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  r;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  b;
  } pix_rec_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  value;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } chan_rec_t;

  typedef struct packed {
    pix_rec_t             bright;
    pix_rec_t             dark;
    chan_rec_t [2:0]      chmax;
    chan_rec_t [2:0]      chmin;
  } snap_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_stat_t;

endpackage

### rtl/image_extrema_statistics.sv
// ----------------------------------------------------------------------------
// Image extrema statistics: one pixel transfer per cycle; the input stalls only
// while two frame summaries wait in the queue. A frame summary goes via the queue
// and back-end snapshot to the output: eight reports, one per cycle unless stalled.
// Synchronous reset clears counters, trackers and queue; width returns to 640.
// ----------------------------------------------------------------------------
module image_extrema_statistics (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iestat_pkg::WIDTH_W-1:0] image_width,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [iestat_pkg::CHAN_W-1:0]  red,
  input  logic [iestat_pkg::CHAN_W-1:0]  green,
  input  logic [iestat_pkg::CHAN_W-1:0]  blue,
  input  logic                           end_of_frame,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [iestat_pkg::KIND_W-1:0]  report_kind,
  output logic [iestat_pkg::COORD_W-1:0] pos_x,
  output logic [iestat_pkg::COORD_W-1:0] pos_y,
  output logic [iestat_pkg::CHAN_W-1:0]  pix_red,
  output logic [iestat_pkg::CHAN_W-1:0]  pix_green,
  output logic [iestat_pkg::CHAN_W-1:0]  pix_blue,
  output logic [iestat_pkg::SUM_W-1:0]   stat_value,
  output logic                           last_report
);
  import iestat_pkg::*;

  queue_stat_t q_stat;
  snap_t       push_data;
  snap_t       pop_data;
  logic        push;
  logic        pop;

  assign cfg_ready = 1'b1;

  iestat_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (image_width),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .end_of_frame (end_of_frame),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  iestat_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  iestat_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_data      (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .report_kind (report_kind),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pix_red     (pix_red),
    .pix_green   (pix_green),
    .pix_blue    (pix_blue),
    .stat_value  (stat_value),
    .last_report (last_report)
  );

endmodule

### rtl/iestat_front.sv
// ----------------------------------------------------------------------------
// Image extrema statistics front end
// Accepts pixels, tracks position and frame extrema, and queues a frame
// summary on the end-of-frame pixel.
// ----------------------------------------------------------------------------
module iestat_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [iestat_pkg::WIDTH_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [iestat_pkg::CHAN_W-1:0] red,
  input  logic [iestat_pkg::CHAN_W-1:0] green,
  input  logic [iestat_pkg::CHAN_W-1:0] blue,
  input  logic                          end_of_frame,
  input  iestat_pkg::queue_stat_t       q_stat,
  output logic                          push,
  output iestat_pkg::snap_t             push_data
);
  import iestat_pkg::*;

  logic [WIDTH_W-1:0] width_reg;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic               frame_open;
  pix_rec_t           bright;
  pix_rec_t           dark;
  chan_rec_t [2:0]    chmax;
  chan_rec_t [2:0]    chmin;

  pix_rec_t           bright_next;
  pix_rec_t           dark_next;
  chan_rec_t [2:0]    chmax_next;
  chan_rec_t [2:0]    chmin_next;
  pix_rec_t           cur;
  logic [CHAN_W-1:0]  chan [3];
  logic [WIDTH_W-1:0] w_eff;
  logic [WIDTH_W-1:0] col_inc;
  logic               accept;
  logic               wrap;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && end_of_frame;

  assign chan[0] = red;
  assign chan[1] = green;
  assign chan[2] = blue;

  always_comb begin
    cur.sum = {2'b00, red} + {2'b00, green} + {2'b00, blue};
    cur.x   = col;
    cur.y   = row;
    cur.r   = red;
    cur.g   = green;
    cur.b   = blue;
    bright_next = (cur.sum > bright.sum) ? cur : bright;
    dark_next   = (cur.sum < dark.sum) ? cur : dark;
    for (int i = 0; i < 3; i++) begin
      if (!frame_open || chan[i] > chmax[i].value) begin
        chmax_next[i] = '{value: chan[i], x: col, y: row};
      end else begin
        chmax_next[i] = chmax[i];
      end
      if (!frame_open || chan[i] < chmin[i].value) begin
        chmin_next[i] = '{value: chan[i], x: col, y: row};
      end else begin
        chmin_next[i] = chmin[i];
      end
    end
  end

  assign push_data = '{bright: bright_next, dark: dark_next,
                       chmax: chmax_next, chmin: chmin_next};

  assign w_eff   = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
  assign col_inc = {1'b0, col} + 13'd1;
  assign wrap    = (col_inc >= w_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= WIDTH_RESET;
    end else if (cfg_valid) begin
      width_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      frame_open <= 1'b0;
      bright     <= '0;
      dark       <= '{sum: DARK_START, default: '0};
      chmax      <= '0;
      chmin      <= '0;
    end else if (accept) begin
      if (end_of_frame) begin
        col        <= '0;
        row        <= '0;
        frame_open <= 1'b0;
        bright     <= '0;
        dark       <= '{sum: DARK_START, default: '0};
        chmax      <= '0;
        chmin      <= '0;
      end else begin
        frame_open <= 1'b1;
        bright     <= bright_next;
        dark       <= dark_next;
        chmax      <= chmax_next;
        chmin      <= chmin_next;
        if (wrap) begin
          col <= '0;
          row <= row + 12'd1;
        end else begin
          col <= col_inc[COORD_W-1:0];
        end
      end
    end
  end

endmodule

### rtl/iestat_queue.sv
// ----------------------------------------------------------------------------
// Image extrema statistics summary queue
// Short first-in first-out buffer of frame summaries between front and back.
// ----------------------------------------------------------------------------
module iestat_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  iestat_pkg::snap_t       push_data,
  input  logic                    pop,
  output iestat_pkg::snap_t       pop_data,
  output iestat_pkg::queue_stat_t q_stat
);
  import iestat_pkg::*;

  snap_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign q_stat.full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_stat.not_empty = (count != '0);
  assign do_push          = push && !q_stat.full;
  assign do_pop           = pop && q_stat.not_empty;
  assign pop_data         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/iestat_back.sv
// ----------------------------------------------------------------------------
// Image extrema statistics back end
// Walks one frame summary through its eight reports into an output register.
// ----------------------------------------------------------------------------
module iestat_back (
  input  logic                           clk,
  input  logic                           rst,
  input  iestat_pkg::queue_stat_t        q_stat,
  input  iestat_pkg::snap_t              q_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [iestat_pkg::KIND_W-1:0]  report_kind,
  output logic [iestat_pkg::COORD_W-1:0] pos_x,
  output logic [iestat_pkg::COORD_W-1:0] pos_y,
  output logic [iestat_pkg::CHAN_W-1:0]  pix_red,
  output logic [iestat_pkg::CHAN_W-1:0]  pix_green,
  output logic [iestat_pkg::CHAN_W-1:0]  pix_blue,
  output logic [iestat_pkg::SUM_W-1:0]   stat_value,
  output logic                           last_report
);
  import iestat_pkg::*;

  snap_t     snap;
  kind_t     kind;
  logic      busy;
  logic      load_out;
  pix_rec_t  sel_pix;
  chan_rec_t sel_chan;
  logic      is_pix;

  assign load_out = busy && (!out_valid || !out_stall);
  assign pop      = q_stat.not_empty && (!busy || (load_out && kind == KIND_MIN_B));

  always_comb begin
    sel_pix  = snap.bright;
    sel_chan = snap.chmax[0];
    is_pix   = 1'b0;
    case (kind)
      KIND_BRIGHT: begin
        sel_pix = snap.bright;
        is_pix  = 1'b1;
      end
      KIND_DARK: begin
        sel_pix = snap.dark;
        is_pix  = 1'b1;
      end
      KIND_MAX_R: sel_chan = snap.chmax[0];
      KIND_MAX_G: sel_chan = snap.chmax[1];
      KIND_MAX_B: sel_chan = snap.chmax[2];
      KIND_MIN_R: sel_chan = snap.chmin[0];
      KIND_MIN_G: sel_chan = snap.chmin[1];
      KIND_MIN_B: sel_chan = snap.chmin[2];
      default:    sel_chan = snap.chmax[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      kind <= KIND_BRIGHT;
    end else if (pop) begin
      busy <= 1'b1;
      kind <= KIND_BRIGHT;
    end else if (load_out) begin
      if (kind == KIND_MIN_B) begin
        busy <= 1'b0;
      end
      kind <= kind_t'(kind + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      snap <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      report_kind <= kind;
      last_report <= (kind == KIND_MIN_B);
      if (is_pix) begin
        pos_x      <= sel_pix.x;
        pos_y      <= sel_pix.y;
        pix_red    <= sel_pix.r;
        pix_green  <= sel_pix.g;
        pix_blue   <= sel_pix.b;
        stat_value <= sel_pix.sum;
      end else begin
        pos_x      <= sel_chan.x;
        pos_y      <= sel_chan.y;
        pix_red    <= '0;
        pix_green  <= '0;
        pix_blue   <= '0;
        stat_value <= {2'b00, sel_chan.value};
      end
    end
  end

endmodule

### rtl/iestat_checker.sv
// ----------------------------------------------------------------------------
// Image extrema statistics checker
// Port-level checks on the report channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iestat_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [iestat_pkg::KIND_W-1:0]  report_kind,
  input logic [iestat_pkg::CHAN_W-1:0]  pix_red,
  input logic [iestat_pkg::CHAN_W-1:0]  pix_green,
  input logic [iestat_pkg::CHAN_W-1:0]  pix_blue,
  input logic [iestat_pkg::SUM_W-1:0]   stat_value,
  input logic                           last_report
);
  import iestat_pkg::*;

  logic [SUM_W-1:0] pix_sum;
  logic             comp_kind;

  assign pix_sum   = {2'b00, pix_red} + {2'b00, pix_green} + {2'b00, pix_blue};
  assign comp_kind = (report_kind != KIND_BRIGHT) && (report_kind != KIND_DARK);

  `CHK_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "report dropped while stalled")
  `CHK_NEXT(a_hold_kind, out_valid && out_stall, $stable(report_kind), "report changed while stalled")
  `CHK_SAME(a_last_kind, out_valid && last_report, report_kind == KIND_MIN_B, "last report has wrong kind")
  `CHK_SAME(a_comp_zero, out_valid && comp_kind, pix_sum == '0, "component report carries color")
  `CHK_SAME(a_pix_sum, out_valid && !comp_kind, stat_value == pix_sum, "pixel report sum mismatch")

endmodule

bind image_extrema_statistics iestat_checker u_iestat_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .report_kind (report_kind),
  .pix_red     (pix_red),
  .pix_green   (pix_green),
  .pix_blue    (pix_blue),
  .stat_value  (stat_value),
  .last_report (last_report)
);

### tb/image_extrema_statistics_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Image extrema statistics testbench
// Streams RGB frames into the block and predicts the eight end-of-frame
// reports from a cycle-free model of the trackers and position counters.
// Reports are checked field by field in order. Both sides idle in random
// bursts, and the row width is changed between frames.
// ----------------------------------------------------------------------------
module image_extrema_statistics_tb;
  import iestat_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic              eof;
  } pixel_t;

  typedef struct {
    kind_t              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  r;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  b;
    logic [SUM_W-1:0]   value;
    logic               last;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WIDTH_W-1:0] image_width = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CHAN_W-1:0] red = '0;
  logic [CHAN_W-1:0] green = '0;
  logic [CHAN_W-1:0] blue = '0;
  logic end_of_frame = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0] report_kind;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [CHAN_W-1:0] pix_red;
  logic [CHAN_W-1:0] pix_green;
  logic [CHAN_W-1:0] pix_blue;
  logic [SUM_W-1:0] stat_value;
  logic last_report;

  pixel_t pixel_feed[$];
  report_t awaited_reports[$];
  pixel_t next_pixel;
  report_t want;
  int send_gap = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  bit calm = 1'b0;

  logic [WIDTH_W-1:0] width_setting;
  logic [COORD_W-1:0] col_pos;
  logic [COORD_W-1:0] row_pos;
  pix_rec_t bright_rec;
  pix_rec_t dark_rec;
  chan_rec_t max_rec [3];
  chan_rec_t min_rec [3];
  bit max_seen [3];
  bit min_seen [3];

  image_extrema_statistics dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .image_width  (image_width),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .report_kind  (report_kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pix_red      (pix_red),
    .pix_green    (pix_green),
    .pix_blue     (pix_blue),
    .stat_value   (stat_value),
    .last_report  (last_report)
  );

  always #5 clk = ~clk;

  task automatic clear_trackers();
    col_pos = '0;
    row_pos = '0;
    bright_rec = '0;
    dark_rec = '0;
    dark_rec.sum = DARK_START;
    for (int i = 0; i < 3; i++) begin
      max_rec[i] = '0;
      min_rec[i] = '0;
      max_seen[i] = 1'b0;
      min_seen[i] = 1'b0;
    end
  endtask

  task automatic absorb_pixel(input logic [CHAN_W-1:0] r, g, b, input logic eof);
    logic [CHAN_W-1:0] chan [3];
    logic [SUM_W-1:0] sum;
    int span;
    report_t rep;
    chan[0] = r;
    chan[1] = g;
    chan[2] = b;
    sum = r + g + b;
    if (sum > bright_rec.sum) begin
      bright_rec = '{sum, col_pos, row_pos, r, g, b};
    end
    if (sum < dark_rec.sum) begin
      dark_rec = '{sum, col_pos, row_pos, r, g, b};
    end
    for (int i = 0; i < 3; i++) begin
      if (!max_seen[i] || chan[i] > max_rec[i].value) begin
        max_seen[i] = 1'b1;
        max_rec[i] = '{chan[i], col_pos, row_pos};
      end
      if (!min_seen[i] || chan[i] < min_rec[i].value) begin
        min_seen[i] = 1'b1;
        min_rec[i] = '{chan[i], col_pos, row_pos};
      end
    end
    if (width_setting == 0) span = 1;
    else if (width_setting > MAX_WIDTH) span = MAX_WIDTH;
    else span = width_setting;
    if (col_pos + 1 >= span) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    if (eof) begin
      rep = '{KIND_BRIGHT, bright_rec.x, bright_rec.y, bright_rec.r, bright_rec.g,
              bright_rec.b, bright_rec.sum, 1'b0};
      awaited_reports.push_back(rep);
      rep = '{KIND_DARK, dark_rec.x, dark_rec.y, dark_rec.r, dark_rec.g,
              dark_rec.b, dark_rec.sum, 1'b0};
      awaited_reports.push_back(rep);
      for (int i = 0; i < 6; i++) begin
        rep.kind = kind_t'(KIND_MAX_R + i);
        rep.x = (i < 3) ? max_rec[i].x : min_rec[i-3].x;
        rep.y = (i < 3) ? max_rec[i].y : min_rec[i-3].y;
        rep.r = '0;
        rep.g = '0;
        rep.b = '0;
        rep.value = (i < 3) ? max_rec[i].value : min_rec[i-3].value;
        rep.last = (rep.kind == KIND_MIN_B);
        awaited_reports.push_back(rep);
      end
      clear_trackers();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v, got_v);
    if (want_v !== got_v) begin
      $error("%s expected %0d got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_setting = WIDTH_RESET;
      clear_trackers();
    end else begin
      if (cfg_valid && cfg_ready) width_setting = image_width;
      if (in_valid && !in_stall) absorb_pixel(red, green, blue, end_of_frame);
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("report kind %0d arrived with nothing expected", report_kind);
          errors++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("report_kind", want.kind, report_kind);
          check_field("pos_x", want.x, pos_x);
          check_field("pos_y", want.y, pos_y);
          check_field("pix_red", want.r, pix_red);
          check_field("pix_green", want.g, pix_green);
          check_field("pix_blue", want.b, pix_blue);
          check_field("stat_value", want.value, stat_value);
          check_field("last_report", want.last, last_report);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        send_gap <= $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (pixel_feed.size() != 0) begin
        next_pixel = pixel_feed.pop_front();
        in_valid <= 1'b1;
        red <= next_pixel.r;
        green <= next_pixel.g;
        blue <= next_pixel.b;
        end_of_frame <= next_pixel.eof;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("image_extrema_statistics verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_pixel(input logic [CHAN_W-1:0] r, g, b, input logic eof);
    pixel_feed.push_back('{r, g, b, eof});
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pixel_feed.size() != 0 || in_valid || awaited_reports.size() != 0);
  endtask

  task automatic write_width(input logic [WIDTH_W-1:0] value);
    drain();
    repeat (12) @(posedge clk);
    cfg_valid <= 1'b1;
    image_width <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random_frames(input int budget);
    int left;
    int len;
    int mode;
    logic [CHAN_W-1:0] gray;
    pixel_t px;
    left = budget;
    px = '0;
    while (left > 0) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        mode = $urandom_range(0, 7);
        if (mode == 0) begin
          px.r = 8'($urandom_range(0, 1) * 255);
          px.g = 8'($urandom_range(0, 1) * 255);
          px.b = 8'($urandom_range(0, 1) * 255);
        end else if (mode == 2) begin
          gray = 8'($urandom);
          px.r = gray;
          px.g = gray;
          px.b = gray;
        end else if (mode != 1) begin
          px.r = 8'($urandom);
          px.g = 8'($urandom);
          px.b = 8'($urandom);
        end
        px.eof = (i == len - 1);
        pixel_feed.push_back(px);
      end
      left -= len;
    end
  endtask

  logic [WIDTH_W-1:0] width_plan [6];

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd10, 8'd20, 8'd30, 1'b0);
    push_pixel(8'd30, 8'd20, 8'd10, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd1, 8'd2, 8'd3, 1'b1);

    write_width('0);
    push_pixel(8'd7, 8'd200, 8'd1, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd128, 8'd64, 8'd32, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd254, 1'b1);

    write_width(13'd3);
    queue_random_frames(7);

    write_width(13'd1);
    queue_random_frames(10);

    write_width('1);
    queue_random_frames(10);

    width_plan[0] = 13'd2;
    width_plan[1] = MAX_WIDTH;
    width_plan[2] = 13'd5;
    width_plan[3] = 13'($urandom_range(1, 64));
    width_plan[4] = WIDTH_RESET;
    width_plan[5] = 13'($urandom_range(0, 8191));
    for (int p = 0; p < 6; p++) begin
      write_width(width_plan[p]);
      if (p == 5) calm = 1'b1;
      queue_random_frames(30);
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && awaited_reports.size() == 0) begin
      $display("image_extrema_statistics verification clean");
    end else begin
      $display("image_extrema_statistics verification failed");
    end
    $finish;
  end

endmodule
